>>> hdl/mcpg_pkg.sv
// Shared types, constants and a helper function of the midpoint circle point generator.
`timescale 1ns / 1ps
package mcpg_pkg;

   localparam int CoordBits = 10;
   localparam int PointBits = CoordBits + 2;
   localparam int ErrBits = CoordBits + 3;
   localparam int DiffBits = CoordBits + 2;
   localparam int QueueDepthDefault = 4;
   localparam int SelBits = 3;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic signed [PointBits-1:0] point_type;
   typedef logic [ErrBits-1:0] err_type;
   typedef logic [DiffBits-1:0] diff_type;
   typedef logic [SelBits-1:0] sel_type;

   typedef enum logic {
      ActStart = 1'b0,
      ActStep = 1'b1
   } action_type;

   typedef struct packed {
      coord_type cx;
      coord_type cy;
      coord_type x;
      coord_type y;
      logic is_start;
      logic done;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   localparam sel_type StartLastIdx = SelBits'(3);
   localparam sel_type StepLastIdx = SelBits'(7);

   // Maps the position of an anchor point to its slot in the eight-way pattern.
   function automatic sel_type start_sel(input logic [1:0] idx);
      sel_type sel;
      case (idx)
         2'd0: sel = SelBits'(0);
         2'd1: sel = SelBits'(2);
         2'd2: sel = SelBits'(4);
         2'd3: sel = SelBits'(5);
         default: sel = SelBits'(0);
      endcase
      return sel;
   endfunction

endpackage

>>> hdl/mcpg_channels.sv
// Valid/ready channel interfaces for requests and plotted points.
`timescale 1ns / 1ps
interface mcpg_req_if;
   import mcpg_pkg::*;
   logic valid;
   logic ready;
   action_type action;
   coord_type center_x;
   coord_type center_y;
   coord_type radius;
   modport source (output valid, action, center_x, center_y, radius, input ready);
   modport sink (input valid, action, center_x, center_y, radius, output ready);
endinterface

interface mcpg_rsp_if;
   import mcpg_pkg::*;
   logic valid;
   logic ready;
   point_type point_x;
   point_type point_y;
   logic last_of_run;
   logic circle_done;
   modport source (output valid, point_x, point_y, last_of_run, circle_done, input ready);
   modport sink (input valid, point_x, point_y, last_of_run, circle_done, output ready);
endinterface

>>> hdl/mcpg_front.sv
// Front end: accepts requests, runs one midpoint iteration per step and issues jobs.
`timescale 1ns / 1ps
module mcpg_front (
   input logic clock,
   input logic reset,
   mcpg_req_if.sink req_chan,
   input mcpg_pkg::queue_stat_type q_stat,
   output logic job_push,
   output mcpg_pkg::job_type job_out
);
   import mcpg_pkg::*;

   coord_type cx_ff, cx_in;
   coord_type cy_ff, cy_in;
   coord_type x_ff, x_in;
   coord_type y_ff, y_in;
   err_type err_ff, err_in;
   diff_type dx_ff, dx_in;
   diff_type dy_ff, dy_in;
   logic active_ff, active_in;

   logic accept;
   coord_type y_dec;
   coord_type x_inc;
   diff_type dy_inc;
   diff_type dx_inc;
   err_type err_mid;
   coord_type y_step;
   diff_type dy_step;
   err_type err_step;
   logic active_step;

   assign req_chan.ready = !q_stat.full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      y_dec = y_ff - CoordBits'(1);
      x_inc = x_ff + CoordBits'(1);
      dy_inc = dy_ff + DiffBits'(2);
      dx_inc = dx_ff + DiffBits'(2);
      if (!err_ff[ErrBits-1]) begin
         y_step = y_dec;
         dy_step = dy_inc;
         err_mid = err_ff + ErrBits'(signed'(dy_inc));
      end else begin
         y_step = y_ff;
         dy_step = dy_ff;
         err_mid = err_ff;
      end
      err_step = err_mid + ErrBits'(signed'(dx_inc)) + ErrBits'(1);
      active_step = x_inc < y_step;
   end

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      x_in = x_ff;
      y_in = y_ff;
      err_in = err_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      active_in = active_ff;
      job_push = 1'b0;
      job_out.cx = cx_ff;
      job_out.cy = cy_ff;
      job_out.x = x_inc;
      job_out.y = y_step;
      job_out.is_start = 1'b0;
      job_out.done = !active_step;
      if (accept) begin
         if (req_chan.action == ActStart) begin
            cx_in = req_chan.center_x;
            cy_in = req_chan.center_y;
            x_in = '0;
            y_in = req_chan.radius;
            err_in = ErrBits'(1) - ErrBits'(req_chan.radius);
            dx_in = '0;
            dy_in = DiffBits'(0) - DiffBits'({req_chan.radius, 1'b0});
            active_in = req_chan.radius != '0;
            job_push = 1'b1;
            job_out.cx = req_chan.center_x;
            job_out.cy = req_chan.center_y;
            job_out.x = '0;
            job_out.y = req_chan.radius;
            job_out.is_start = 1'b1;
            job_out.done = req_chan.radius == '0;
         end else if (active_ff) begin
            x_in = x_inc;
            y_in = y_step;
            err_in = err_step;
            dx_in = dx_inc;
            dy_in = dy_step;
            active_in = active_step;
            job_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
         err_ff <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         x_ff <= x_in;
         y_ff <= y_in;
         err_ff <= err_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         active_ff <= active_in;
      end
   end

endmodule

>>> hdl/mcpg_queue.sv
// Small job queue between the front end and the point emitter.
`timescale 1ns / 1ps
module mcpg_queue #(
   parameter int Depth = mcpg_pkg::QueueDepthDefault
) (
   input logic clock,
   input logic reset,
   input logic push,
   input mcpg_pkg::job_type push_job,
   input logic pop,
   output mcpg_pkg::job_type head_job,
   output mcpg_pkg::queue_stat_type q_stat
);
   import mcpg_pkg::*;

   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountBits = $clog2(Depth + 1);

   job_type entries_ff [Depth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   assign head_job = entries_ff[rd_ptr_ff];
   assign q_stat.full = count_ff == CountBits'(Depth);
   assign q_stat.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hdl/mcpg_back.sv
// Back end: expands each job into its symmetric points, one point per cycle while the result port is ready.
`timescale 1ns / 1ps
module mcpg_back (
   input logic clock,
   input logic reset,
   input mcpg_pkg::job_type head_job,
   input mcpg_pkg::queue_stat_type q_stat,
   output logic pop,
   mcpg_rsp_if.source rsp_chan
);
   import mcpg_pkg::*;

   job_type job_ff, job_in;
   logic busy_ff, busy_in;
   sel_type idx_ff, idx_in;
   logic out_valid_ff, out_valid_in;
   point_type px_ff, px_in;
   point_type py_ff, py_in;
   logic last_ff, last_in;
   logic done_ff, done_in;

   logic can_load;
   logic at_last;
   sel_type sel;
   coord_type h_val;
   coord_type v_val;
   logic [PointBits-1:0] h_ext;
   logic [PointBits-1:0] v_ext;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.point_x = px_ff;
   assign rsp_chan.point_y = py_ff;
   assign rsp_chan.last_of_run = last_ff;
   assign rsp_chan.circle_done = done_ff;

   assign can_load = !out_valid_ff || rsp_chan.ready;
   assign at_last = idx_ff == (job_ff.is_start ? StartLastIdx : StepLastIdx);
   assign pop = (!busy_ff || (can_load && at_last)) && !q_stat.empty;

   always_comb begin
      sel = job_ff.is_start ? start_sel(idx_ff[1:0]) : idx_ff;
      h_val = sel[2] ? job_ff.y : job_ff.x;
      v_val = sel[2] ? job_ff.x : job_ff.y;
      h_ext = sel[0] ? PointBits'(0) - PointBits'(h_val) : PointBits'(h_val);
      v_ext = sel[1] ? PointBits'(0) - PointBits'(v_val) : PointBits'(v_val);
   end

   always_comb begin
      job_in = job_ff;
      busy_in = busy_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff;
      px_in = px_ff;
      py_in = py_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (can_load) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            px_in = signed'(PointBits'(job_ff.cx) + h_ext);
            py_in = signed'(PointBits'(job_ff.cy) + v_ext);
            last_in = at_last;
            done_in = at_last && job_ff.done;
            if (at_last) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff + SelBits'(1);
            end
         end
      end
      if (pop) begin
         job_in = head_job;
         busy_in = 1'b1;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      px_ff <= px_in;
      py_ff <= py_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

endmodule

>>> hdl/midpoint_circle_point_generator_unit.sv
// Top level of the midpoint circle point generator.
// A start request latches the center and radius and yields the four anchor points; each step
// request runs one midpoint iteration and yields the eight symmetric points, the last one
// flagged last_of_run and, when the octant is finished, circle_done. A step with no circle in
// progress yields nothing. The front end takes one request per cycle while the queue is not
// full and does the iteration in that cycle; jobs wait in a QUEUE_DEPTH-entry queue for the
// point emitter, which drives one point per cycle through its output register while the
// result port is ready, so the result port sets the sustained rate: eight points per step
// request, four per start. Requests reach the first point via queue, job and output registers.
`timescale 1ns / 1ps
module midpoint_circle_point_generator_unit #(
   parameter int QUEUE_DEPTH = mcpg_pkg::QueueDepthDefault
) (
   input logic clock,
   input logic reset,
   mcpg_req_if.sink req_chan,
   mcpg_rsp_if.source rsp_chan
);
   import mcpg_pkg::*;

   queue_stat_type q_stat;
   logic job_push;
   logic job_pop;
   job_type push_job;
   job_type head_job;

   mcpg_front u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .q_stat(q_stat),
      .job_push(job_push),
      .job_out(push_job)
   );

   mcpg_queue #(
      .Depth(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_job(push_job),
      .pop(job_pop),
      .head_job(head_job),
      .q_stat(q_stat)
   );

   mcpg_back u_back (
      .clock(clock),
      .reset(reset),
      .head_job(head_job),
      .q_stat(q_stat),
      .pop(job_pop),
      .rsp_chan(rsp_chan)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_stat.full)
      else $error("Job pushed into a full queue.");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !q_stat.empty)
      else $error("Job popped from an empty queue.");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.circle_done |-> rsp_chan.last_of_run)
      else $error("Circle done flagged on a point that does not end its transfer run.");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("Result valid right after reset.");

endmodule
